@@ rtl/slip_frame_decoder_top_defines.svh @@
// Assertion macros for the SLIP frame decoder.
`ifndef SLIP_FRAME_DECODER_TOP_DEFINES_SVH
`define SLIP_FRAME_DECODER_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sfd_pkg.sv @@
package sfd_pkg;

   typedef logic [1:0] kind_type;
   typedef logic [7:0] byte_type;

   localparam kind_type KIND_BYTE       = 2'd0;
   localparam kind_type KIND_OVERFLOW   = 2'd1;
   localparam kind_type KIND_BAD_ESCAPE = 2'd2;

   localparam byte_type CODE_END     = 8'hC0;
   localparam byte_type CODE_ESC     = 8'hDB;
   localparam byte_type CODE_ESC_END = 8'hDC;
   localparam byte_type CODE_ESC_ESC = 8'hDD;

   localparam int MIN_EMIT_LEN = 4;

   localparam int LIMIT_W = 7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

endpackage

@@ rtl/sfd_ram.sv @@
module sfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/slip_frame_decoder_top.sv @@
// SLIP receive decoder. One stuffed byte is taken per cycle while no frame is being
// played out and no result is held by rsp_stall; decoded bytes go into a single-port-read
// frame store. An END that closes a frame of N bytes (N above four) holds the request
// side while the store is read back one word per cycle through its one read port, as
// long as rsp_stall does not hold results back. Errors and short frames start no playout.
// The frame store is not cleared; only bytes of the current frame are ever read.
`include "slip_frame_decoder_top_defines.svh"

module slip_frame_decoder_top #(
   parameter int MAX_FRAME = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sfd_pkg::kind_type     rsp_kind,
   output logic [7:0]            rsp_frame_byte,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [6:0]            csr_wr_data
);

   import sfd_pkg::*;

   localparam int ADDR_W = $clog2(MAX_FRAME);
   localparam int POS_W  = $clog2(MAX_FRAME + 1);
   localparam int CMP_W  = (POS_W > LIMIT_W) ? POS_W : LIMIT_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAME);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic                state_ff, state_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                esc_ff, esc_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [POS_W-1:0]    cnt_ff, cnt_in;
   logic [POS_W-1:0]    idx_ff, idx_in;
   logic                rd_pending_ff, rd_pending_in;
   logic                rd_last_ff, rd_last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic                accept;
   logic [CMP_W-1:0]    pos_cmp;
   logic [CMP_W-1:0]    limit_cmp;
   logic [CMP_W-1:0]    eff_limit;
   logic                wr_en;
   logic [7:0]          wr_data;
   logic                err_load;
   kind_type            err_kind;
   logic                emit_start;
   logic                load_rd;
   logic                issue;
   logic [7:0]          rd_data;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign pos_cmp   = CMP_W'(pos_ff);
   assign limit_cmp = CMP_W'(limit_ff);
   assign eff_limit = (limit_cmp > MAX_CMP) ? MAX_CMP : limit_cmp;

   // decode one accepted word
   always_comb begin
      pos_in     = pos_ff;
      esc_in     = esc_ff;
      wr_en      = 1'b0;
      wr_data    = req_rx_byte;
      err_load   = 1'b0;
      err_kind   = KIND_OVERFLOW;
      emit_start = 1'b0;
      if (accept) begin
         priority if (pos_cmp >= eff_limit) begin
            pos_in   = '0;
            esc_in   = 1'b0;
            err_load = 1'b1;
            err_kind = KIND_OVERFLOW;
         end else if (req_rx_byte == CODE_END) begin
            emit_start = (pos_ff > POS_W'(MIN_EMIT_LEN));
            pos_in     = '0;
            esc_in     = 1'b0;
         end else if (req_rx_byte == CODE_ESC) begin
            esc_in = 1'b1;
         end else if (esc_ff) begin
            esc_in = 1'b0;
            priority if (req_rx_byte == CODE_ESC_END) begin
               wr_en   = 1'b1;
               wr_data = CODE_END;
               pos_in  = pos_ff + 1'b1;
            end else if (req_rx_byte == CODE_ESC_ESC) begin
               wr_en   = 1'b1;
               wr_data = CODE_ESC;
               pos_in  = pos_ff + 1'b1;
            end else begin
               pos_in   = '0;
               err_load = 1'b1;
               err_kind = KIND_BAD_ESCAPE;
            end
         end else begin
            wr_en  = 1'b1;
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // play out the stored frame
   assign load_rd = rd_pending_ff && out_free;
   assign issue   = (state_ff == ST_EMIT) && (idx_ff < cnt_ff) && (!rd_pending_ff || load_rd);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      rd_pending_in = rd_pending_ff;
      rd_last_in    = rd_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (emit_start) begin
               state_in = ST_EMIT;
               cnt_in   = pos_ff;
               idx_in   = '0;
            end
         end
         ST_EMIT: begin
            if (issue) begin
               idx_in        = idx_ff + 1'b1;
               rd_pending_in = 1'b1;
               rd_last_in    = ((idx_ff + 1'b1) == cnt_ff);
            end else if (load_rd) begin
               rd_pending_in = 1'b0;
            end
            if (load_rd && rd_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      priority if (err_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = err_kind;
         rsp_byte_in  = '0;
         rsp_last_in  = 1'b1;
      end else if (load_rd) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_BYTE;
         rsp_byte_in  = rd_data;
         rsp_last_in  = rd_last_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         esc_ff        <= 1'b0;
         limit_ff      <= LIMIT_RESET;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         esc_ff        <= esc_in;
         rd_pending_ff <= rd_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rd_last_ff  <= rd_last_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   sfd_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FRAME)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_last       = rsp_last_ff;

   `SFD_ASSERT_NOW(a_no_accept_in_emit, clock, reset, state_ff == ST_EMIT, req_stall, "word accepted during frame playout")
   `SFD_ASSERT_NOW(a_read_only_in_emit, clock, reset, rd_pending_ff, state_ff == ST_EMIT, "frame store read outside playout")
   `SFD_ASSERT_NOW(a_error_shape, clock, reset, rsp_valid_ff && (rsp_kind_ff != KIND_BYTE), rsp_last_ff && (rsp_byte_ff == 8'h00), "malformed error result")
   `SFD_ASSERT_NEXT(a_pos_bound, clock, reset, 1'b1, pos_ff <= POS_W'(MAX_FRAME), "write position beyond frame store")

endmodule

@@ tb/tb.sv @@
module tb;
   import sfd_pkg::*;

   localparam int FRAME_DEPTH = 64;
   localparam int PHASE_WORDS = 30;
   localparam int CFG_SETTLE = 16;
   localparam int END_SETTLE = 100;
   localparam logic [LIMIT_W-1:0] LIMIT_STEPS [8] =
      '{7'd127, 7'd1, 7'd5, 7'd0, 7'd64, 7'd6, 7'd40, 7'd64};

   typedef struct packed {
      kind_type kind;
      byte_type data;
      logic     last;
   } result_type;

   class slip_scoreboard;
      byte_type           frame_mem [FRAME_DEPTH];
      int                 write_pos;
      bit                 esc_open;
      logic [LIMIT_W-1:0] limit;
      result_type         due[$];
      int                 errors;

      function void clear();
         write_pos = 0;
         esc_open = 1'b0;
         limit = LIMIT_RESET;
         due.delete();
         errors = 0;
      endfunction

      function void add_result(kind_type k, byte_type d, logic l);
         result_type r;
         r.kind = k;
         r.data = d;
         r.last = l;
         due.push_back(r);
      endfunction

      function void keep_byte(byte_type d);
         if (write_pos < FRAME_DEPTH) begin
            frame_mem[write_pos] = d;
            write_pos++;
         end
      endfunction

      function void take_word(byte_type w);
         int eff;
         eff = (int'(limit) > FRAME_DEPTH) ? FRAME_DEPTH : int'(limit);
         if (write_pos >= eff) begin
            write_pos = 0;
            esc_open = 1'b0;
            add_result(KIND_OVERFLOW, 8'h00, 1'b1);
            return;
         end
         if (w == CODE_END) begin
            if (write_pos > MIN_EMIT_LEN) begin
               for (int i = 0; i < write_pos; i++)
                  add_result(KIND_BYTE, frame_mem[i], (i + 1 == write_pos));
            end
            esc_open = 1'b0;
            write_pos = 0;
         end else if (w == CODE_ESC) begin
            esc_open = 1'b1;
         end else if (esc_open) begin
            if (w == CODE_ESC_END) begin
               keep_byte(CODE_END);
            end else if (w == CODE_ESC_ESC) begin
               keep_byte(CODE_ESC);
            end else begin
               esc_open = 1'b0;
               write_pos = 0;
               add_result(KIND_BAD_ESCAPE, 8'h00, 1'b1);
               return;
            end
            esc_open = 1'b0;
         end else begin
            keep_byte(w);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("tb: unexpected result kind=%0d byte=%02h last=%0d",
                        got.kind, got.data, got.last);
            return;
         end
         want = due.pop_front();
         if (got.kind !== want.kind || got.data !== want.data || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
               $display("tb: mismatch expected kind=%0d byte=%02h last=%0d, got kind=%0d byte=%02h last=%0d",
                        want.kind, want.data, want.last, got.kind, got.data, got.last);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   kind_type           rsp_kind;
   logic [7:0]         rsp_frame_byte;
   logic               rsp_last;
   logic               csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   slip_scoreboard sb = new();
   bit             calm = 1'b0;
   int             words_sent = 0;

   slip_frame_decoder_top #(
      .MAX_FRAME(FRAME_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 35);
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result('{rsp_kind, rsp_frame_byte, rsp_last});
   end

   function automatic byte_type pick_byte();
      case ($urandom_range(9))
         0: pick_byte = CODE_END;
         1: pick_byte = CODE_ESC;
         2: pick_byte = CODE_ESC_END;
         3: pick_byte = CODE_ESC_ESC;
         default: pick_byte = byte_type'($urandom_range(255));
      endcase
   endfunction

   task automatic send_word(byte_type w);
      if (!calm && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.take_word(w);
      words_sent++;
   endtask

   task automatic send_frame(int len);
      byte_type d;
      for (int i = 0; i < len; i++) begin
         d = pick_byte();
         if (d == CODE_END) begin
            send_word(CODE_ESC);
            send_word(CODE_ESC_END);
         end else if (d == CODE_ESC) begin
            send_word(CODE_ESC);
            send_word(CODE_ESC_ESC);
         end else begin
            send_word(d);
         end
      end
      send_word(CODE_END);
   endtask

   task automatic drain(int settle);
      req_valid <= 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] v);
      drain(CFG_SETTLE);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.limit = v;
   endtask

   task automatic random_traffic(int n);
      int       target;
      int       eff;
      int       r;
      byte_type d;
      target = words_sent + n;
      eff = (int'(sb.limit) > FRAME_DEPTH) ? FRAME_DEPTH : int'(sb.limit);
      while (words_sent < target) begin
         r = $urandom_range(99);
         if (r < 70) begin
            r = $urandom_range(99);
            if (r < 75)
               send_frame($urandom_range(0, 8));
            else if (r < 90)
               send_frame($urandom_range(0, eff));
            else
               send_frame(eff + $urandom_range(0, 1));
         end else if (r < 80) begin
            send_word(CODE_ESC);
            do d = byte_type'($urandom_range(255));
            while (d inside {CODE_END, CODE_ESC, CODE_ESC_END, CODE_ESC_ESC});
            send_word(d);
         end else if (r < 88) begin
            repeat ($urandom_range(1, 3)) send_word(CODE_ESC);
            send_word($urandom_range(1) ? CODE_END : CODE_ESC_END);
         end else begin
            repeat ($urandom_range(1, 3)) send_word(byte_type'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      sb.clear();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= 8'h00;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_word(CODE_END);
      send_word(8'h00);
      send_word(8'hFF);
      send_word(CODE_ESC);
      send_word(CODE_ESC_END);
      send_word(CODE_ESC);
      send_word(CODE_ESC_ESC);
      send_word(8'h7F);
      send_word(CODE_END);
      send_word(8'h01);
      send_word(8'h02);
      send_word(8'h03);
      send_word(8'h04);
      send_word(CODE_END);
      send_word(CODE_ESC);
      send_word(8'h41);
      send_word(CODE_ESC);
      send_word(CODE_ESC);
      send_word(CODE_ESC_END);
      send_word(CODE_ESC);
      send_word(CODE_END);
      write_limit(7'd0);
      send_word(CODE_END);
      send_word(CODE_ESC);

      for (int p = 0; p < 8; p++) begin
         write_limit(LIMIT_STEPS[p]);
         calm <= (p == 4);
         random_traffic(PHASE_WORDS / 2);
         if (p == 2)
            drain(CFG_SETTLE);
         random_traffic(PHASE_WORDS - PHASE_WORDS / 2);
      end
      calm <= 1'b0;

      drain(END_SETTLE);
      if (sb.errors == 0 && sb.due.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: FAIL");
      $finish;
   end
endmodule
